[sv/fce_pkg.sv]
// ----------------------------------------------------------------------------
// fce_pkg
// shared constants and controller/datapath interface types for the front
// coding string encoder
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam int BLOCK_STRINGS = 16;
  localparam int MAX_LEN       = 62;

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int DEPTH  = 2 * MAX_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = (BLOCK_STRINGS > 1) ? $clog2(BLOCK_STRINGS) : 1;

  // controller to datapath
  typedef struct packed {
    logic take;     // input transaction, latch byte and flags
    logic cmp;      // match compare and store of the latched byte
    logic ld_pfx;   // load prefix length into output register
    logic ld_sfx;   // load suffix length into output register
    logic ld_data;  // load one suffix byte from the store
    logic close;    // string done, swap banks and reset counters
    logic rd_emit;  // read address follows the emit pointer
  } fce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic str_end;     // latched item closes the string
    logic sfx_zero;    // suffix length is zero
    logic data_last;   // emit pointer is on the final suffix byte
    logic out_free;    // output register can take a new byte
  } fce_status_t;

endpackage

[sv/fce_ram.sv]
// ----------------------------------------------------------------------------
// fce_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/fce_ctrl.sv]
// ----------------------------------------------------------------------------
// fce_ctrl
// sequencer: byte intake, match pass, header bytes and suffix readout
// ----------------------------------------------------------------------------
module fce_ctrl
  import fce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  fce_status_t status,
  output fce_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_HDR_P,
    S_HDR_S,
    S_RD,
    S_LD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = status.str_end ? S_HDR_P : S_IDLE;
      end
      S_HDR_P: begin
        if (status.out_free) begin
          cmd.ld_pfx = 1'b1;
          state_nxt  = S_HDR_S;
        end
      end
      S_HDR_S: begin
        if (status.out_free) begin
          cmd.ld_sfx = 1'b1;
          if (status.sfx_zero) begin
            cmd.close = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_emit = 1'b1;
        state_nxt   = S_LD;
      end
      S_LD: begin
        // address held so read data stays valid while stalled
        cmd.rd_emit = 1'b1;
        if (status.out_free) begin
          cmd.ld_data = 1'b1;
          if (status.data_last) begin
            cmd.close = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/fce_dp.sv]
// ----------------------------------------------------------------------------
// fce_dp
// datapath: two-bank string store, length and match counters, output register
// ----------------------------------------------------------------------------
module fce_dp
  import fce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fce_cmd_t    cmd,
  output fce_status_t status,
  input  logic [7:0]  in_byte,
  input  logic        in_eos,
  input  logic        in_empty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_bs,
  output logic        out_tl
);

  // latched input transaction
  logic [7:0]       byte_r;
  logic             eos_r;
  logic             empty_r;

  logic             bank_r, bank_nxt;
  logic [LEN_W-1:0] last_len_r, last_len_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0] match_r, match_nxt;
  logic             still_r, still_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] pos_r;

  logic             oval_r;
  logic [7:0]       obyte_r;
  logic             olast_r;
  logic             obs_r;
  logic             otl_r;

  logic [ADDR_W-1:0] cur_base, prv_base, waddr, raddr;
  logic [7:0]        rdata;
  logic              we;
  logic              room;
  logic              bs;
  logic [LEN_W-1:0]  pfx_raw, prefix, suffix;
  logic              load;

  assign cur_base = bank_r ? ADDR_W'(MAX_LEN) : '0;
  assign prv_base = bank_r ? '0 : ADDR_W'(MAX_LEN);
  assign room     = (cur_len_r < LEN_W'(MAX_LEN));
  assign we       = cmd.cmp && !empty_r && room;
  assign waddr    = cur_base + ADDR_W'(cur_len_r);
  assign raddr    = cmd.rd_emit ? (cur_base + ADDR_W'(pos_r))
                                : (prv_base + ADDR_W'(cur_len_r));

  fce_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (byte_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign bs      = (idx_r == '0);
  assign pfx_raw = bs ? '0 : match_r;
  assign prefix  = (pfx_raw > cur_len_r) ? cur_len_r : pfx_raw;
  assign suffix  = cur_len_r - prefix;
  assign load    = cmd.ld_pfx || cmd.ld_sfx || cmd.ld_data;

  assign status.str_end   = eos_r || empty_r;
  assign status.sfx_zero  = (suffix == '0);
  assign status.data_last = (({1'b0, pos_r} + (LEN_W+1)'(1)) == {1'b0, cur_len_r});
  assign status.out_free  = !oval_r || out_ready;

  always_comb begin
    bank_nxt     = bank_r;
    last_len_nxt = last_len_r;
    cur_len_nxt  = cur_len_r;
    match_nxt    = match_r;
    still_nxt    = still_r;
    idx_nxt      = idx_r;
    ovf_nxt      = ovf_r;
    if (cmd.cmp && !empty_r) begin
      if (!room) begin
        ovf_nxt = 1'b1;
      end else begin
        // rdata holds the previous string's byte at this position
        if (still_r && (cur_len_r < last_len_r) && (rdata == byte_r)) begin
          match_nxt = match_r + LEN_W'(1);
        end else begin
          still_nxt = 1'b0;
        end
        cur_len_nxt = cur_len_r + LEN_W'(1);
      end
    end
    if (cmd.close) begin
      last_len_nxt = cur_len_r;
      bank_nxt     = ~bank_r;
      cur_len_nxt  = '0;
      match_nxt    = '0;
      still_nxt    = 1'b1;
      ovf_nxt      = 1'b0;
      idx_nxt      = (idx_r == IDX_W'(BLOCK_STRINGS - 1)) ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= 1'b0;
      last_len_r <= '0;
      cur_len_r  <= '0;
      match_r    <= '0;
      still_r    <= 1'b1;
      idx_r      <= '0;
      ovf_r      <= 1'b0;
      oval_r     <= 1'b0;
    end else begin
      bank_r     <= bank_nxt;
      last_len_r <= last_len_nxt;
      cur_len_r  <= cur_len_nxt;
      match_r    <= match_nxt;
      still_r    <= still_nxt;
      idx_r      <= idx_nxt;
      ovf_r      <= ovf_nxt;
      if (load) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r  <= in_byte;
      eos_r   <= in_eos;
      empty_r <= in_empty;
    end
    if (cmd.ld_sfx) begin
      pos_r <= prefix;
    end else if (cmd.ld_data) begin
      pos_r <= pos_r + LEN_W'(1);
    end
    if (cmd.ld_pfx) begin
      obyte_r <= 8'(prefix);
      olast_r <= 1'b0;
      obs_r   <= bs;
      otl_r   <= ovf_r;
    end else if (cmd.ld_sfx) begin
      obyte_r <= 8'(suffix);
      olast_r <= (suffix == '0);
      obs_r   <= 1'b0;
      otl_r   <= ovf_r;
    end else if (cmd.ld_data) begin
      obyte_r <= rdata;
      olast_r <= status.data_last;
      obs_r   <= 1'b0;
      otl_r   <= ovf_r;
    end
  end

  assign out_valid = oval_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_bs    = obs_r;
  assign out_tl    = otl_r;

  // match can never run past the bytes gathered
  a_match_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    match_r <= cur_len_r)
    else $error("match length exceeds current length");

  // no store write once the string is at its length limit
  a_write_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (cur_len_r < LEN_W'(MAX_LEN)))
    else $error("store write beyond bank");

  // block start only ever marks a prefix byte, which is never the last
  a_bs_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && obs_r) |-> !olast_r)
    else $error("block start on a final byte");

  // a new byte never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !out_ready) |=> (oval_r && $stable(obyte_r)))
    else $error("pending output byte lost");

endmodule

[sv/front_coding_string_encoder.sv]
// ----------------------------------------------------------------------------
// front_coding_string_encoder
// front coding of a byte stream of strings: prefix length, suffix length,
// suffix bytes, with the prefix restarted at each block of strings
// ----------------------------------------------------------------------------
//  channel | dir | tdata        | tlast          | tuser
//  in_     | in  | data_byte    | end_of_string  | empty_string
//  out_    | out | out_byte     | out_last       | [0] block_start [1] too_long
//
//  an input byte is taken as the transaction, then the match and store
//  pass, which waits on the registered read of the string store
//  a closed string adds the two length bytes, and each suffix byte takes a read
//  state and a load state, since readout shares the store's single read port
//  rst_n is synchronous and active low; the store needs no clearing pass
//  output stalls hold the sequencer, input stays not ready until done
// ----------------------------------------------------------------------------
module front_coding_string_encoder
  import fce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  input  logic       in_tuser,   // [0] empty_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] block_start, [1] too_long
);

  fce_cmd_t    cmd;
  fce_status_t status;

  fce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fce_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (in_tdata),
    .in_eos    (in_tlast),
    .in_empty  (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_bs    (out_tuser[0]),
    .out_tl    (out_tuser[1])
  );

endmodule

[sim/front_coding_string_encoder_tb.sv]
// ----------------------------------------------------------------------------
// front_coding_string_encoder_tb
// self-checking bench for the front coding string encoder: a queue-fed driver
// pushes string bytes, a predictor builds the prefix/suffix coding of every
// closed string, and a monitor compares each output transaction in order
// ----------------------------------------------------------------------------
module front_coding_string_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fce_pkg::*;

  localparam int RUN_ITEMS   = 330;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 300;
  localparam int GEN_MAX     = 80;
  localparam int REPORT_CAP  = 40;

  typedef struct {
    logic [7:0]  data;
    logic        eos;
    logic        empty;
    logic        drain;
    int unsigned gap;
  } str_item_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
    logic       bs;
    logic       tl;
  } code_byte_t;

  logic       clk = 1'b1;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  front_coding_string_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // coding predictor
  // ---------------------------------------------------------------------------
  logic [7:0]       str_mem [0:DEPTH-1];
  logic             cur_bank = 1'b0;
  logic [LEN_W-1:0] last_len = '0;
  logic [LEN_W-1:0] cur_len = '0;
  logic [LEN_W-1:0] match_len = '0;
  logic             matching = 1'b1;
  logic [IDX_W-1:0] blk_idx = '0;
  logic             trunc_seen = 1'b0;

  code_byte_t pending_codes[$];
  int unsigned fail_count = 0;

  task automatic add_code(input code_byte_t c);
    pending_codes.insert(pending_codes.size(), c);
  endtask

  task automatic front_code_step(input logic [7:0] b, input logic eos, input logic empty);
    int cur_base;
    int prv_base;
    int prefix;
    int suffix;
    logic bs;
    cur_base = cur_bank ? MAX_LEN : 0;
    prv_base = cur_bank ? 0 : MAX_LEN;
    if (!empty) begin
      if (cur_len >= MAX_LEN) begin
        trunc_seen = 1'b1;
      end else begin
        if (matching && cur_len < last_len && str_mem[prv_base + cur_len] == b) begin
          match_len = match_len + 1'b1;
        end else begin
          matching = 1'b0;
        end
        str_mem[cur_base + cur_len] = b;
        cur_len = cur_len + 1'b1;
      end
      if (!eos) return;
    end
    bs = (blk_idx == 0);
    prefix = bs ? 0 : int'(match_len);
    if (prefix > int'(cur_len)) prefix = cur_len;
    suffix = int'(cur_len) - prefix;
    add_code('{8'(prefix), 1'b0, bs, trunc_seen});
    add_code('{8'(suffix), suffix == 0, 1'b0, trunc_seen});
    for (int i = 0; i < suffix; i++) begin
      add_code('{str_mem[cur_base + prefix + i], i + 1 == suffix, 1'b0, trunc_seen});
    end
    last_len = cur_len;
    cur_bank = !cur_bank;
    cur_len = '0;
    match_len = '0;
    matching = 1'b1;
    trunc_seen = 1'b0;
    blk_idx = IDX_W'((int'(blk_idx) + 1) % BLOCK_STRINGS);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  str_item_t   tx_q[$];
  str_item_t   tx_next;
  int unsigned tx_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
      in_tuser  <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) front_code_step(in_tdata, in_tlast, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap    <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (tx_q.size() != 0 && (!tx_q[0].drain || pending_codes.size() == 0)) begin
          tx_next   = tx_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= tx_next.data;
          in_tlast  <= tx_next.eos;
          in_tuser  <= tx_next.empty;
          tx_gap    <= tx_next.gap;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor
  // ---------------------------------------------------------------------------
  int unsigned rx_stall = 0;
  logic        rx_calm = 1'b0;

  task automatic check_code(input logic [7:0] val, input logic last, input logic [1:0] user);
    code_byte_t want;
    if (pending_codes.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: unexpected transaction, byte %h last %b tuser %b",
                 $time, val, last, user);
      return;
    end
    want = pending_codes.pop_front();
    if (val !== want.val) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: out_byte expected %h actual %h", $time, want.val, val);
    end
    if (last !== want.last) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: out_last expected %b actual %b", $time, want.last, last);
    end
    if (user[0] !== want.bs) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: block_start expected %b actual %b", $time, want.bs, user[0]);
    end
    if (user[1] !== want.tl) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: too_long expected %b actual %b", $time, want.tl, user[1]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
    end else begin
      if (out_tvalid && out_tready) check_code(out_tdata, out_tlast, out_tuser);
      if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
      if (rx_stall != 0) begin
        rx_stall   <= rx_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall   <= rx_calm ? 0 : pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[front_coding_string_encoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [7:0] gen_prev [0:GEN_MAX-1];
  int         gen_prev_len = 0;
  int         tx_items = 0;
  logic       tx_calm = 1'b0;

  task automatic queue_item(input logic [7:0] d, input logic eos, input logic empty,
                            input logic drain);
    str_item_t it;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    it.data  = d;
    it.eos   = eos;
    it.empty = empty;
    it.drain = drain;
    it.gap   = tx_calm ? 0 : pick_gap();
    tx_q.insert(tx_q.size(), it);
    tx_items++;
  endtask

  // share bytes of the previous string give it a common prefix to find
  task automatic queue_string(input int len, input int share, input logic via_empty,
                              input logic drain);
    logic [7:0] s [0:GEN_MAX-1];
    for (int i = 0; i < len; i++)
      s[i] = (i < share && i < gen_prev_len) ? gen_prev[i] : 8'($urandom);
    for (int i = 0; i < len; i++)
      queue_item(s[i], !via_empty && i == len - 1, 1'b0, drain && i == 0);
    if (via_empty || len == 0)
      queue_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, drain && len == 0);
    for (int i = 0; i < len; i++) gen_prev[i] = s[i];
    gen_prev_len = len;
  endtask

  initial begin
    int rand_start;
    int len;
    int r;
    // empty string at the very start, then single-byte extremes
    queue_item(8'hFF, 1'b0, 1'b1, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0, 1'b0);
    // full repeat: suffix length zero
    queue_item(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_item(8'h55, 1'b1, 1'b0, 1'b0);
    // closed by an empty mark with end also set, its byte is ignored
    queue_item(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_item(8'hAA, 1'b0, 1'b0, 1'b0);
    queue_item(8'h3C, 1'b1, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    queue_item(8'h80, 1'b1, 1'b0, 1'b0);
    // longer than the previous string
    queue_item(8'h80, 1'b0, 1'b0, 1'b0);
    queue_item(8'h01, 1'b0, 1'b0, 1'b0);
    queue_item(8'h7F, 1'b1, 1'b0, 1'b0);
    queue_item(8'h80, 1'b0, 1'b0, 1'b0);
    queue_item(8'h01, 1'b1, 1'b0, 1'b0);
    gen_prev[0] = 8'h80;
    gen_prev[1] = 8'h01;
    gen_prev_len = 2;

    rand_start = tx_items;
    // truncated strings, the second one matching past the length limit
    queue_string(66, 0, 1'b0, 1'b1);
    queue_string(70, 70, 1'b0, 1'b0);
    while (tx_items - rand_start < RUN_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) len = 0;
      else if (r < 85) len = $urandom_range(1, 8);
      else if (r < 96) len = $urandom_range(9, 30);
      else len = $urandom_range(55, 70);
      queue_string(len, $urandom_range(0, 1) ? $urandom_range(0, len + 1) : 0,
                   $urandom_range(0, 6) == 0, $urandom_range(0, 59) == 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (tx_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[front_coding_string_encoder] OK");
    end else begin
      $display("[front_coding_string_encoder] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/fce_pkg.sv
sv/fce_ram.sv
sv/fce_ctrl.sv
sv/fce_dp.sv
sv/front_coding_string_encoder.sv
sim/front_coding_string_encoder_tb.sv
